// ===== design/edd_pkg.sv =====
// Shared constants and types for the error-diffusion dither.
package edd_pkg;

    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int SAMPLE_BITS_DEF = 8;
    localparam int SAMPLE_W        = 8;
    localparam int LINE_W          = 12;
    localparam logic [LINE_W-1:0] LINE_WIDTH_RST = 12'd640;
    localparam int QUEUE_DEPTH     = 4;
    localparam int N_CH            = 3;

    typedef struct packed {
        logic bank;
        logic skip_above;
        logic row_start;
        logic row_end;
    } t_item_ctl;

    localparam int CTL_W = $bits(t_item_ctl);

endpackage

// ===== design/error_diffusion_dither.sv =====
// Top level of the Floyd-Steinberg error-diffusion dither, RGB in, one bit per channel out.
// Path: queue, back-end stage register, then output register; stalls can hold a pixel.
// Throughput: one pixel per cycle unless stalled, set by the back-end right-carry loop.
// Reset: synchronous, active low; clears handshake state, sets line width to 640 and
// restarts the frame. The row error store is not cleared; the first row never reads it.
module error_diffusion_dither import edd_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [SAMPLE_W-1:0] i_red_sample,
    input  logic [SAMPLE_W-1:0] i_green_sample,
    input  logic [SAMPLE_W-1:0] i_blue_sample,
    input  logic                i_start_of_frame,
    input  logic                i_cfg_wr_en,
    input  logic [LINE_W-1:0]   i_cfg_wr_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_red_bit,
    output logic                o_green_bit,
    output logic                o_blue_bit
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = CTL_W + CW + N_CH * SAMPLE_BITS;

    logic                   q_full;
    logic                   push;
    t_item_ctl              f_ctl;
    logic [CW-1:0]          f_col;
    logic [SAMPLE_BITS-1:0] f_red, f_green, f_blue;
    logic [QW-1:0]          q_wr_data, q_rd_data;
    logic                   q_valid;
    logic                   pop;
    t_item_ctl              q_ctl;
    logic [CW-1:0]          q_col;
    logic [SAMPLE_BITS-1:0] q_red, q_green, q_blue;

    assign o_in_stall = q_full;
    assign q_wr_data  = {f_ctl, f_col, f_red, f_green, f_blue};
    assign {q_ctl, q_col, q_red, q_green, q_blue} = q_rd_data;

    edd_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_red_sample     (i_red_sample),
        .i_green_sample   (i_green_sample),
        .i_blue_sample    (i_blue_sample),
        .i_start_of_frame (i_start_of_frame),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_ctl            (f_ctl),
        .o_col            (f_col),
        .o_red            (f_red),
        .o_green          (f_green),
        .o_blue           (f_blue)
    );

    edd_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_rd_data)
    );

    edd_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_ctl       (q_ctl),
        .i_col       (q_col),
        .i_red       (q_red),
        .i_green     (q_green),
        .i_blue      (q_blue),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_red_bit   (o_red_bit),
        .o_green_bit (o_green_bit),
        .o_blue_bit  (o_blue_bit)
    );

endmodule

// ===== design/edd_front.sv =====
// Front end: pixel intake, line width register, row and column tracking.
module edd_front import edd_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int CW         = $clog2(MAX_WIDTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [SAMPLE_W-1:0]    i_red_sample,
    input  logic [SAMPLE_W-1:0]    i_green_sample,
    input  logic [SAMPLE_W-1:0]    i_blue_sample,
    input  logic                   i_start_of_frame,
    input  logic                   i_cfg_wr_en,
    input  logic [LINE_W-1:0]      i_cfg_wr_data,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_item_ctl              o_ctl,
    output logic [CW-1:0]          o_col,
    output logic [SAMPLE_BITS-1:0] o_red,
    output logic [SAMPLE_BITS-1:0] o_green,
    output logic [SAMPLE_BITS-1:0] o_blue
);

    localparam int PW   = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CMPW = (LINE_W > CW + 1) ? LINE_W : CW + 1;

    logic [LINE_W-1:0] r_line_width, n_line_width;
    logic [CW-1:0]     r_col, n_col;
    logic              r_bank, n_bank;
    logic              r_first, n_first;

    logic [CW-1:0]   col;
    logic            first;
    logic            last;
    logic [CMPW-1:0] col_inc;
    logic [PW-1:0]   red_x, green_x, blue_x;

    assign o_push = i_in_valid && !i_q_full;

    always_comb begin
        red_x   = PW'(i_red_sample);
        green_x = PW'(i_green_sample);
        blue_x  = PW'(i_blue_sample);
        o_red   = red_x[SAMPLE_BITS-1:0];
        o_green = green_x[SAMPLE_BITS-1:0];
        o_blue  = blue_x[SAMPLE_BITS-1:0];

        col     = i_start_of_frame ? '0 : r_col;
        first   = i_start_of_frame || r_first;
        col_inc = CMPW'(col) + CMPW'(1);
        last    = (r_line_width == '0) || (col_inc >= CMPW'(r_line_width))
                  || (col_inc >= CMPW'(MAX_WIDTH));

        o_col            = col;
        o_ctl.bank       = r_bank;
        o_ctl.skip_above = first;
        o_ctl.row_start  = (col == '0);
        o_ctl.row_end    = last;

        n_line_width = i_cfg_wr_en ? i_cfg_wr_data : r_line_width;
        n_col        = r_col;
        n_bank       = r_bank;
        n_first      = r_first;
        if (o_push) begin
            if (last) begin
                n_col   = '0;
                n_bank  = !r_bank;
                n_first = 1'b0;
            end else begin
                n_col   = col_inc[CW-1:0];
                n_first = first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_col        <= '0;
            r_bank       <= 1'b0;
            r_first      <= 1'b1;
        end else begin
            r_line_width <= n_line_width;
            r_col        <= n_col;
            r_bank       <= n_bank;
            r_first      <= n_first;
        end
    end

endmodule

// ===== design/edd_queue.sv =====
// Short FIFO between the front end and the diffusion back end.
module edd_queue import edd_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/edd_back.sv =====
// Back end: row error store, threshold, error spread and output register.
module edd_back import edd_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int CW         = $clog2(MAX_WIDTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_item_ctl              i_ctl,
    input  logic [CW-1:0]          i_col,
    input  logic [SAMPLE_BITS-1:0] i_red,
    input  logic [SAMPLE_BITS-1:0] i_green,
    input  logic [SAMPLE_BITS-1:0] i_blue,
    output logic                   o_pop,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic                   o_red_bit,
    output logic                   o_green_bit,
    output logic                   o_blue_bit
);

    localparam int EW     = SAMPLE_BITS + 5;
    localparam int DW     = N_CH * EW;
    localparam int DEPTH  = 2 ** CW;
    localparam int FULL_I = 16 * ((1 << SAMPLE_BITS) - 1);
    localparam int HALF_I = 8 * ((1 << SAMPLE_BITS) - 1);
    localparam logic signed [EW:0]   FULL_X = (EW+1)'(FULL_I);
    localparam logic signed [EW:0]   NEG_X  = (EW+1)'(-FULL_I);
    localparam logic signed [EW:0]   HALF_X = (EW+1)'(HALF_I);
    localparam logic signed [EW-1:0] FULL_E = EW'(FULL_I);
    localparam logic signed [EW-1:0] NEG_E  = EW'(-FULL_I);

    logic [DW-1:0] r_mem_even [DEPTH];
    logic [DW-1:0] r_mem_odd  [DEPTH];
    logic [DW-1:0] r_rd_even, r_rd_odd;
    logic          r_byp_hit;
    logic [DW-1:0] r_byp_data;

    logic                   r_b_valid;
    t_item_ctl              r_b_ctl;
    logic [CW-1:0]          r_b_col;
    logic [SAMPLE_BITS-1:0] r_b_smp [N_CH];

    logic signed [EW-1:0] r_carry     [N_CH];
    logic signed [EW-1:0] r_pend_prev [N_CH];
    logic signed [EW-1:0] r_pend_cur  [N_CH];
    logic signed [EW-1:0] n_carry     [N_CH];
    logic signed [EW-1:0] n_pend_prev [N_CH];
    logic signed [EW-1:0] n_pend_cur  [N_CH];

    logic          r_out_valid;
    logic [N_CH-1:0] r_out_bits, n_out_bits;

    logic            b_fire;
    logic [CW:0]     rd_full, wr_prev_full, wr_cur_full;
    logic [CW-1:0]   rd_addr, wr_prev_addr, wr_cur_addr;
    logic            we_prev, we_cur;
    logic            we_even, we_odd;
    logic [CW-1:0]   addr_even, addr_odd;
    logic [DW-1:0]   data_even, data_odd;
    logic [DW-1:0]   wr_prev_vec, wr_cur_vec, above_vec;
    logic            byp_hit;
    logic [DW-1:0]   byp_data;

    logic signed [EW-1:0] above, cin, acc, e, s1, s3, s5, s7, pcur;
    logic signed [EW:0]   acc_w, corr, e_x;
    logic signed [EW+1:0] e3, t3;
    logic signed [EW+2:0] e5, e7, t5, t7;
    logic                 hi;

    assign b_fire      = r_b_valid && (!r_out_valid || !i_out_stall);
    assign o_pop       = i_q_valid && (!r_b_valid || b_fire);
    assign o_out_valid = r_out_valid;
    assign o_red_bit   = r_out_bits[0];
    assign o_green_bit = r_out_bits[1];
    assign o_blue_bit  = r_out_bits[2];

    // Addresses: bank bit above the column, column parity picks the memory.
    always_comb begin
        rd_full      = {i_ctl.bank, i_col};
        rd_addr      = rd_full[CW:1];
        wr_prev_full = {!r_b_ctl.bank, r_b_col - CW'(1)};
        wr_prev_addr = wr_prev_full[CW:1];
        wr_cur_full  = {!r_b_ctl.bank, r_b_col};
        wr_cur_addr  = wr_cur_full[CW:1];
        we_prev      = b_fire && !r_b_ctl.row_start;
        we_cur       = b_fire && r_b_ctl.row_end;

        if (r_b_col[0]) begin
            we_even   = we_prev;
            addr_even = wr_prev_addr;
            data_even = wr_prev_vec;
            we_odd    = we_cur;
            addr_odd  = wr_cur_addr;
            data_odd  = wr_cur_vec;
        end else begin
            we_even   = we_cur;
            addr_even = wr_cur_addr;
            data_even = wr_cur_vec;
            we_odd    = we_prev;
            addr_odd  = wr_prev_addr;
            data_odd  = wr_prev_vec;
        end

        if (i_col[0]) begin
            byp_hit  = we_odd && (addr_odd == rd_addr);
            byp_data = data_odd;
        end else begin
            byp_hit  = we_even && (addr_even == rd_addr);
            byp_data = data_even;
        end

        if (r_byp_hit) begin
            above_vec = r_byp_data;
        end else begin
            above_vec = r_b_col[0] ? r_rd_odd : r_rd_even;
        end
    end

    always_comb begin
        above = '0;
        cin   = '0;
        acc_w = '0;
        acc   = '0;
        corr  = '0;
        hi    = 1'b0;
        e_x   = '0;
        e     = '0;
        e3    = '0;
        e5    = '0;
        e7    = '0;
        t3    = '0;
        t5    = '0;
        t7    = '0;
        s1    = '0;
        s3    = '0;
        s5    = '0;
        s7    = '0;
        pcur  = '0;
        wr_prev_vec = '0;
        wr_cur_vec  = '0;
        n_out_bits  = '0;
        for (int ch = 0; ch < N_CH; ch++) begin
            above = r_b_ctl.skip_above ? '0 : $signed(above_vec[ch*EW +: EW]);
            cin   = r_b_ctl.row_start ? '0 : r_carry[ch];
            acc_w = (EW+1)'(above) + (EW+1)'(cin);
            if (acc_w > FULL_X) begin
                acc = FULL_E;
            end else if (acc_w < NEG_X) begin
                acc = NEG_E;
            end else begin
                acc = acc_w[EW-1:0];
            end
            corr = $signed({2'b00, r_b_smp[ch], 4'b0000}) + (EW+1)'(acc);
            hi   = (corr > HALF_X);
            e_x  = hi ? corr - FULL_X : corr;
            e    = e_x[EW-1:0];

            e3 = $signed({e[EW-1], e, 1'b0}) + (EW+2)'(e);
            e5 = $signed({e[EW-1], e, 2'b00}) + (EW+3)'(e);
            e7 = $signed({e, 3'b000}) - (EW+3)'(e);
            t3 = e3 >>> 4;
            t5 = e5 >>> 4;
            t7 = e7 >>> 4;
            s1 = e >>> 4;
            s3 = t3[EW-1:0];
            s5 = t5[EW-1:0];
            s7 = t7[EW-1:0];

            pcur = r_b_ctl.row_start ? '0 : r_pend_cur[ch];
            wr_prev_vec[ch*EW +: EW] = r_pend_prev[ch] + s3;
            wr_cur_vec[ch*EW +: EW]  = pcur + s5;
            n_pend_prev[ch] = pcur + s5;
            n_pend_cur[ch]  = s1;
            n_carry[ch]     = s7;
            n_out_bits[ch]  = hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_even) begin
            r_mem_even[addr_even] <= data_even;
        end
        if (o_pop) begin
            r_rd_even <= r_mem_even[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_odd) begin
            r_mem_odd[addr_odd] <= data_odd;
        end
        if (o_pop) begin
            r_rd_odd <= r_mem_odd[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byp_hit  <= byp_hit;
            r_byp_data <= byp_data;
            r_b_ctl    <= i_ctl;
            r_b_col    <= i_col;
            r_b_smp[0] <= i_red;
            r_b_smp[1] <= i_green;
            r_b_smp[2] <= i_blue;
        end
        if (b_fire) begin
            r_out_bits <= n_out_bits;
            for (int ch = 0; ch < N_CH; ch++) begin
                r_carry[ch]     <= n_carry[ch];
                r_pend_prev[ch] <= n_pend_prev[ch];
                r_pend_cur[ch]  <= n_pend_cur[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== design/edd_checker.sv =====
// Port-level checker for the dither, bound to the top level.
module edd_port_checker import edd_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_red_bit,
    input logic o_green_bit,
    input logic o_blue_bit
);

    localparam int MAX_FLIGHT = QUEUE_DEPTH + 2;
    localparam int FW         = $clog2(MAX_FLIGHT + 2);

    logic          in_xfer, out_xfer;
    logic [FW-1:0] r_inflight;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_inflight <= r_inflight + FW'(1);
        end else if (out_xfer && !in_xfer) begin
            r_inflight <= r_inflight - FW'(1);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable({o_red_bit, o_green_bit, o_blue_bit}))
        else $error("stalled result changed or dropped");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_inflight != '0)
        else $error("result without a pending input");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= FW'(MAX_FLIGHT))
        else $error("more pixels in flight than the pipeline holds");

    a_empty_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == '0 |-> !o_in_stall)
        else $error("input stalled with nothing in flight");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("handshake active right after reset");

endmodule

bind error_diffusion_dither edd_port_checker u_edd_checker (.*);

// ===== tb/edd_checker.sv =====
// Checker for the error-diffusion dither: predicts the bits of every pixel and compares results.
module edd_checker import edd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [SAMPLE_W-1:0] i_red_sample,
    input  logic [SAMPLE_W-1:0] i_green_sample,
    input  logic [SAMPLE_W-1:0] i_blue_sample,
    input  logic                i_start_of_frame,
    input  logic                i_cfg_wr_en,
    input  logic [LINE_W-1:0]   i_cfg_wr_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_red_bit,
    input  logic                i_green_bit,
    input  logic                i_blue_bit,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int FULL_SCALE = 16 * SAMPLE_MAX;
    localparam int HALF_SCALE = 8 * SAMPLE_MAX;

    int                err_rows [2][MAX_WIDTH_DEF][N_CH];
    int                right_err [N_CH];
    int                column;
    logic              bank;
    logic              top_row;
    logic [LINE_W-1:0] line_width;
    logic [N_CH-1:0]   expected_bits [$];
    string             chan_names [N_CH];
    int                results_seen;

    initial begin
        chan_names[0] = "red";
        chan_names[1] = "green";
        chan_names[2] = "blue";
    end

    function automatic int row_span(logic [LINE_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(v);
    endfunction

    function automatic int sixteenth(int x);
        return x >>> 4;
    endfunction

    task automatic dither_pixel(input logic [N_CH-1:0][SAMPLE_W-1:0] smp, input logic sof,
                                output logic [N_CH-1:0] bits);
        int   span, c, acc, corr, e, ch;
        logic last, hit;
        span = row_span(line_width);
        if (sof) begin
            column  = 0;
            top_row = 1'b1;
            for (ch = 0; ch < N_CH; ch++) right_err[ch] = 0;
        end
        c    = (column >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : column;
        last = (c + 1 >= span);
        for (ch = 0; ch < N_CH; ch++) begin
            acc = top_row ? 0 : err_rows[bank][c][ch];
            if (c > 0) acc += right_err[ch];
            if (acc > FULL_SCALE) acc = FULL_SCALE;
            else if (acc < -FULL_SCALE) acc = -FULL_SCALE;
            corr     = 16 * (int'(smp[ch]) & SAMPLE_MAX) + acc;
            hit      = (corr > HALF_SCALE);
            e        = hit ? corr - FULL_SCALE : corr;
            bits[ch] = hit;
            right_err[ch] = last ? 0 : sixteenth(7 * e);
            if (c > 0) begin
                err_rows[~bank][c-1][ch] += sixteenth(3 * e);
                err_rows[~bank][c][ch]   += sixteenth(5 * e);
            end else begin
                err_rows[~bank][c][ch] = sixteenth(5 * e);
            end
            if (!last) err_rows[~bank][c+1][ch] = sixteenth(e);
        end
        if (last) begin
            column  = 0;
            bank    = ~bank;
            top_row = 1'b0;
            for (ch = 0; ch < N_CH; ch++) right_err[ch] = 0;
        end else begin
            column = c + 1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic [N_CH-1:0] got, want, bits;
        int              ch, b, x;
        if (!i_rst_n) begin
            for (b = 0; b < 2; b++)
                for (x = 0; x < MAX_WIDTH_DEF; x++)
                    for (ch = 0; ch < N_CH; ch++) err_rows[b][x][ch] = 0;
            for (ch = 0; ch < N_CH; ch++) right_err[ch] = 0;
            column       = 0;
            bank         = 1'b0;
            top_row      = 1'b1;
            line_width   = LINE_WIDTH_RST;
            o_fail_count = 0;
            results_seen = 0;
            expected_bits.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_blue_bit, i_green_bit, i_red_bit};
                results_seen++;
                if (expected_bits.size() == 0) begin
                    $display("%0t: result %0d expected none, got bgr %03b",
                             $time, results_seen, got);
                    o_fail_count++;
                end else begin
                    want = expected_bits.pop_front();
                    for (ch = 0; ch < N_CH; ch++) begin
                        if (got[ch] !== want[ch]) begin
                            $display("%0t: result %0d %s_bit expected %0b, got %0b",
                                     $time, results_seen, chan_names[ch], want[ch], got[ch]);
                            o_fail_count++;
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                dither_pixel({i_blue_sample, i_green_sample, i_red_sample},
                             i_start_of_frame, bits);
                expected_bits.insert(expected_bits.size(), bits);
            end
            if (i_cfg_wr_en) line_width = i_cfg_wr_data;
        end
        o_pending = expected_bits.size();
    end

endmodule

// ===== tb/tb_error_diffusion_dither.sv =====
// Testbench top for the error-diffusion dither: drives pixels and line widths, gives the verdict.
module tb_error_diffusion_dither;
    import edd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 60;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int TAIL_ITEMS    = 120;
    localparam int SETTLE_CYCLES = 12;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic                frame_start;
    logic                cfg_en;
    logic [LINE_W-1:0]   cfg_data;
    logic                out_valid;
    logic                out_stall;
    logic                red_bit;
    logic                green_bit;
    logic                blue_bit;
    int                  fail_total;
    int                  pending_results;

    logic                quiet          = 1'b0;
    logic                gaps_on        = 1'b1;
    logic                sof_owed       = 1'b0;
    logic [LINE_W-1:0]   width_now      = LINE_WIDTH_RST;
    int                  hold_serial    = 0;
    int                  col_pos        = 0;
    int                  pixels_sent    = 0;
    int                  frames_started = 0;
    int                  widths_written = 0;
    int                  random_sent    = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    error_diffusion_dither u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_red_sample     (red),
        .i_green_sample   (green),
        .i_blue_sample    (blue),
        .i_start_of_frame (frame_start),
        .i_cfg_wr_en      (cfg_en),
        .i_cfg_wr_data    (cfg_data),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_red_bit        (red_bit),
        .o_green_bit      (green_bit),
        .o_blue_bit       (blue_bit)
    );

    edd_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_red_sample     (red),
        .i_green_sample   (green),
        .i_blue_sample    (blue),
        .i_start_of_frame (frame_start),
        .i_cfg_wr_en      (cfg_en),
        .i_cfg_wr_data    (cfg_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_red_bit        (red_bit),
        .i_green_bit      (green_bit),
        .i_blue_bit       (blue_bit),
        .o_fail_count     (fail_total),
        .o_pending        (pending_results)
    );

    function automatic int row_span(logic [LINE_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_level();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1) ? 8'd128 : 8'd127;
            3:       return SAMPLE_W'($urandom_range(0, 15));
            4:       return SAMPLE_W'($urandom_range(240, 255));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [SAMPLE_W-1:0] r, g, b, input logic sof);
        int   gap;
        logic sof_eff;
        sof_eff  = sof | sof_owed;
        sof_owed = 1'b0;
        gap = (quiet || !gaps_on || $urandom_range(3) != 0) ? 0 : $urandom_range(1, 6);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        red         <= r;
        green       <= g;
        blue        <= b;
        frame_start <= sof_eff;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (sof_eff) begin
            col_pos = 0;
            frames_started++;
        end
        col_pos = (col_pos + 1 >= row_span(width_now)) ? 0 : col_pos + 1;
        pixels_sent++;
    endtask

    task automatic send_pixels_random(input int n);
        int k;
        for (k = 0; k < n; k++) send_pixel(pick_level(), pick_level(), pick_level(), 1'b0);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
    endtask

    // a wider row would read store entries never written: start a new frame then
    task automatic write_line_width(input logic [LINE_W-1:0] v);
        wait_results_done();
        cfg_en   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_en <= 1'b0;
        if (row_span(v) > row_span(width_now)) sof_owed = 1'b1;
        width_now = v;
        widths_written++;
    endtask

    initial begin : receiver
        int   hold_served, level_len;
        logic level;
        hold_served = 0;
        out_stall   = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_serial != hold_served) begin
                hold_served = hold_serial;
                level       = 1'b1;
                level_len   = LONG_HOLD;
            end else if (quiet) begin
                level     = 1'b0;
                level_len = 1;
            end else if ($urandom_range(3) == 0) begin
                level     = 1'b1;
                level_len = $urandom_range(1, 6);
            end else begin
                level     = 1'b0;
                level_len = $urandom_range(1, 12);
            end
            out_stall <= level;
            repeat (level_len - 1) @(negedge clk);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: cycle limit reached, %0d results outstanding", $time, pending_results);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int                  span, frames, rows, extra, f, i;
        logic                flat;
        logic [SAMPLE_W-1:0] base_r, base_g, base_b;
        logic [LINE_W-1:0]   next_w;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        red         = '0;
        green       = '0;
        blue        = '0;
        frame_start = 1'b0;
        cfg_en      = 1'b0;
        cfg_data    = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        write_line_width(12'd3);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h80, 8'h7F, 8'h80, 1'b0);
        send_pixel(8'h7F, 8'h80, 8'h7F, 1'b0);
        send_pixel(8'h01, 8'hFE, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h80, 1'b0);
        send_pixel(8'h80, 8'h80, 8'h80, 1'b0);
        send_pixel(8'h7F, 8'h7F, 8'h7F, 1'b0);
        send_pixel(8'hC8, 8'h32, 8'h64, 1'b0);
        send_pixel(8'h0A, 8'h14, 8'h1E, 1'b0);
        // frame restart on the last pixel of a row, not at a row start
        send_pixel(8'hFF, 8'hFF, 8'h00, 1'b1);
        // grow, then shrink below the current column: that pixel ends the row
        write_line_width(12'd8);
        send_pixels_random(5);
        write_line_width(12'd2);
        send_pixels_random(3);
        write_line_width(12'd0);
        send_pixels_random(3);

        // fill the block while the output is held off
        write_line_width(12'd5);
        gaps_on = 1'b0;
        hold_serial++;
        send_pixels_random(48);
        gaps_on = 1'b1;

        // widest settings: above the store depth and at it
        write_line_width(12'hFFF);
        send_pixels_random(10);
        write_line_width(LINE_W'(MAX_WIDTH_DEF));
        send_pixels_random(10);

        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       next_w = 12'd0;
                1:       next_w = 12'd1;
                2:       next_w = 12'd2;
                3:       next_w = LINE_W'($urandom_range(25, 70));
                default: next_w = LINE_W'($urandom_range(3, 16));
            endcase
            write_line_width(next_w);
            span   = row_span(width_now);
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                rows   = $urandom_range(1, 5);
                flat   = ($urandom_range(2) == 0);
                base_r = pick_level();
                base_g = pick_level();
                base_b = pick_level();
                for (i = 0; i < rows * span; i++) begin
                    if (flat && $urandom_range(3) != 0)
                        send_pixel(base_r, base_g, base_b, i == 0);
                    else
                        send_pixel(pick_level(), pick_level(), pick_level(),
                                   (i == 0) || ($urandom_range(63) == 0));
                    random_sent++;
                end
            end
            extra = $urandom_range(0, span - 1);
            send_pixels_random(extra);
            random_sent += extra;
            if (col_pos > 1 && $urandom_range(2) == 0) begin
                write_line_width(LINE_W'($urandom_range(1, col_pos)));
                span = row_span(width_now);
                send_pixels_random(2 * span);
                random_sent += 2 * span;
            end
            if ($urandom_range(7) == 0) wait_results_done();
        end

        quiet = 1'b1;
        write_line_width(LINE_W'($urandom_range(3, 12)));
        send_pixels_random(TAIL_ITEMS);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d pixels in %0d frame starts over %0d line width writes, 0 to 4095,",
                 pixels_sent, frames_started, widths_written);
        $display("with a long output hold-off, bursty idling on both sides and an idle-free tail.");
        if (fail_total == 0 && pending_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== error_diffusion_dither.f =====
design/edd_pkg.sv
design/edd_front.sv
design/edd_queue.sv
design/edd_back.sv
design/error_diffusion_dither.sv
design/edd_checker.sv
tb/edd_checker.sv
tb/tb_error_diffusion_dither.sv
